// ===== rtl/wspc_pkg.sv =====
package wspc_pkg;

  localparam int unsigned ActionW = 4;
  localparam int unsigned DirW    = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned StepsW  = 16;
  localparam int unsigned DegW    = 9;
  localparam int unsigned VoltW   = 12;
  localparam int unsigned SetpW   = 13;

  localparam int unsigned PotScale  = 9;
  localparam int unsigned PotOffset = 500;
  localparam int unsigned PotBand   = 25;
  localparam int unsigned MaxDeg    = 360;
  localparam int unsigned DegMax    = 511;

  // The reciprocal is exact for every reading below 2**VoltW while PotScale stays below 16.
  localparam int unsigned RecipShift = VoltW + 8;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned Recip      = ((2 ** RecipShift) + PotScale - 1) / PotScale;
  localparam int unsigned ProdW      = VoltW + RecipW;
  localparam int unsigned QuotW      = ProdW - RecipShift;

  typedef enum logic [ActionW-1:0] {
    ActPowerOn  = 4'd0,
    ActPowerOff = 4'd1,
    ActStepMove = 4'd2,
    ActPosStart = 4'd3,
    ActSample   = 4'd4,
    ActTick     = 4'd5,
    ActDirQuery = 4'd6,
    ActPosQuery = 4'd7,
    ActStop     = 4'd8
  } action_e;

  typedef enum logic [DirW-1:0] {
    DirCw      = 2'd0,
    DirCcw     = 2'd1,
    DirRest    = 2'd2,
    DirInvalid = 2'd3
  } dir_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StNoPower    = 3'd1,
    StBadDir     = 3'd2,
    StOutOfRange = 3'd3,
    StAlready    = 3'd4,
    StReached    = 3'd5,
    StReversed   = 3'd6,
    StSensorFail = 3'd7
  } status_e;

endpackage

// ===== rtl/winch_stepper_position_controller_unit.sv =====
// Channel | Direction | Handshake                 | Payload
// input   | in        | in_valid_i / in_stall_o   | action, direction_req, step_count,
//         |           |                           | target_degrees, pot_voltage, pot_fault
// result  | out       | out_valid_o / out_stall_i | status, motor_power, step_running,
//         |           |                           | dir_level, direction_out,
//         |           |                           | steps_remaining, position_deg
//
// One beat enters per cycle while in_stall_o is low; it passes from the input register into the result register.
// The path between the input register and the result register holds the event
// decode, the setpoint scaling multiply and the reciprocal multiply of the position query.
// Reset (rst_ni low) clears the motor state and empties both registers.
// A stalled result beat holds the result register; the input register then fills and
// in_stall_o rises, so the input side stalls once the input register holds a beat.
module winch_stepper_position_controller_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [wspc_pkg::ActionW-1:0]            action_i,
  input  logic [wspc_pkg::DirW-1:0]               direction_req_i,
  input  logic signed [wspc_pkg::StepsW-1:0]      step_count_i,
  input  logic [wspc_pkg::DegW-1:0]               target_degrees_i,
  input  logic [wspc_pkg::VoltW-1:0]              pot_voltage_i,
  input  logic                                    pot_fault_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [wspc_pkg::StatusW-1:0]            status_o,
  output logic                                    motor_power_o,
  output logic                                    step_running_o,
  output logic                                    dir_level_o,
  output logic [wspc_pkg::DirW-1:0]               direction_out_o,
  output logic signed [wspc_pkg::StepsW-1:0]      steps_remaining_o,
  output logic [wspc_pkg::DegW-1:0]               position_deg_o
);

  localparam int unsigned CmpW = wspc_pkg::SetpW + 1;

  // Input register.
  logic                                s1_valid_q;
  logic [wspc_pkg::ActionW-1:0]        s1_action_q;
  logic [wspc_pkg::DirW-1:0]           s1_dreq_q;
  logic signed [wspc_pkg::StepsW-1:0]  s1_count_q;
  logic [wspc_pkg::DegW-1:0]           s1_target_q;
  logic [wspc_pkg::VoltW-1:0]          s1_volt_q;
  logic                                s1_fault_q;

  // Controller state.
  logic                                powered_q, powered_d;
  logic                                running_q, running_d;
  logic                                tick_en_q, tick_en_d;
  logic                                dir_pin_q, dir_pin_d;
  wspc_pkg::dir_e                      move_dir_q, move_dir_d;
  logic [wspc_pkg::SetpW-1:0]          setpoint_q, setpoint_d;
  logic signed [wspc_pkg::StepsW-1:0]  steps_left_q, steps_left_d;

  // Result register.
  logic                                out_valid_q;
  wspc_pkg::status_e                   status_q, status_d;
  wspc_pkg::dir_e                      dir_out_q, dir_out_d;
  logic [wspc_pkg::DegW-1:0]           pos_q, pos_d;

  logic                                in_accept;
  logic                                advance;

  logic [wspc_pkg::SetpW-1:0]          new_setp;
  logic [CmpW-1:0]                     volt_ext;
  logic [CmpW-1:0]                     sp_ext;
  logic [CmpW-1:0]                     new_sp_ext;
  logic                                overshoot;
  logic                                in_band;
  logic [wspc_pkg::VoltW-1:0]          pos_diff;
  logic [wspc_pkg::ProdW-1:0]          pos_prod;
  logic [wspc_pkg::QuotW-1:0]          pos_quot;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_dreq_q   <= direction_req_i;
      s1_count_q  <= step_count_i;
      s1_target_q <= target_degrees_i;
      s1_volt_q   <= pot_voltage_i;
      s1_fault_q  <= pot_fault_i;
    end
    if (advance) begin
      status_q  <= status_d;
      dir_out_q <= dir_out_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q    <= 1'b0;
      running_q    <= 1'b0;
      tick_en_q    <= 1'b0;
      dir_pin_q    <= 1'b0;
      move_dir_q   <= wspc_pkg::DirCw;
      setpoint_q   <= '0;
      steps_left_q <= '0;
    end else if (advance) begin
      powered_q    <= powered_d;
      running_q    <= running_d;
      tick_en_q    <= tick_en_d;
      dir_pin_q    <= dir_pin_d;
      move_dir_q   <= move_dir_d;
      setpoint_q   <= setpoint_d;
      steps_left_q <= steps_left_d;
    end
  end

  assign new_setp = wspc_pkg::SetpW'(
      {4'd0, s1_target_q} * wspc_pkg::SetpW'(wspc_pkg::PotScale)
      + wspc_pkg::SetpW'(wspc_pkg::PotOffset));

  assign volt_ext   = CmpW'(s1_volt_q);
  assign sp_ext     = CmpW'(setpoint_q);
  assign new_sp_ext = CmpW'(new_setp);

  assign overshoot = ((move_dir_q == wspc_pkg::DirCw) && (volt_ext > sp_ext)) ||
                     ((move_dir_q == wspc_pkg::DirCcw) && (volt_ext < sp_ext));
  assign in_band   = (volt_ext <= sp_ext + CmpW'(wspc_pkg::PotBand)) &&
                     (volt_ext + CmpW'(wspc_pkg::PotBand) >= sp_ext);

  assign pos_diff = s1_volt_q - wspc_pkg::VoltW'(wspc_pkg::PotOffset);
  assign pos_prod = wspc_pkg::ProdW'(pos_diff) *
                    wspc_pkg::ProdW'(wspc_pkg::Recip);
  assign pos_quot = pos_prod[wspc_pkg::ProdW-1:wspc_pkg::RecipShift];

  always_comb begin
    powered_d    = powered_q;
    running_d    = running_q;
    tick_en_d    = tick_en_q;
    dir_pin_d    = dir_pin_q;
    move_dir_d   = move_dir_q;
    setpoint_d   = setpoint_q;
    steps_left_d = steps_left_q;
    status_d     = wspc_pkg::StOk;
    pos_d        = '0;
    dir_out_d    = wspc_pkg::DirCw;
    unique case (s1_action_q)
      wspc_pkg::ActPowerOn: begin
        powered_d = 1'b1;
      end
      wspc_pkg::ActPowerOff: begin
        powered_d = 1'b0;
      end
      wspc_pkg::ActStepMove: begin
        if (!powered_q) begin
          status_d = wspc_pkg::StNoPower;
        end else if (s1_dreq_q[1]) begin
          status_d = wspc_pkg::StBadDir;
        end else begin
          dir_pin_d    = s1_dreq_q[0];
          steps_left_d = s1_count_q;
          running_d    = 1'b1;
          tick_en_d    = 1'b1;
        end
      end
      wspc_pkg::ActPosStart: begin
        setpoint_d = new_setp;
        if (s1_target_q > wspc_pkg::DegW'(wspc_pkg::MaxDeg)) begin
          status_d = wspc_pkg::StOutOfRange;
        end else if (!powered_q) begin
          status_d = wspc_pkg::StNoPower;
        end else begin
          move_dir_d = wspc_pkg::dir_e'(s1_dreq_q);
          if (s1_dreq_q == wspc_pkg::DirRest) begin
            status_d = wspc_pkg::StAlready;
          end else if (s1_dreq_q == wspc_pkg::DirInvalid) begin
            status_d = wspc_pkg::StBadDir;
          end else begin
            dir_pin_d = s1_dreq_q[0];
            running_d = 1'b1;
          end
        end
      end
      wspc_pkg::ActSample: begin
        if (s1_fault_q) begin
          status_d = wspc_pkg::StSensorFail;
        end else if (overshoot) begin
          running_d  = 1'b0;
          move_dir_d = (move_dir_q == wspc_pkg::DirCw) ? wspc_pkg::DirCcw
                                                       : wspc_pkg::DirCw;
          status_d   = wspc_pkg::StReversed;
        end else if (in_band) begin
          running_d = 1'b0;
          status_d  = wspc_pkg::StReached;
        end
      end
      wspc_pkg::ActTick: begin
        if (tick_en_q && running_q) begin
          if (steps_left_q[wspc_pkg::StepsW-1] || (steps_left_q == '0)) begin
            tick_en_d    = 1'b0;
            running_d    = 1'b0;
            steps_left_d = '0;
          end else begin
            steps_left_d = steps_left_q - wspc_pkg::StepsW'(1);
          end
        end
      end
      wspc_pkg::ActDirQuery: begin
        if (s1_fault_q) begin
          status_d = wspc_pkg::StSensorFail;
        end
      end
      wspc_pkg::ActPosQuery: begin
        if (s1_fault_q) begin
          status_d = wspc_pkg::StSensorFail;
        end else if (s1_volt_q < wspc_pkg::VoltW'(wspc_pkg::PotOffset)) begin
          status_d = wspc_pkg::StOutOfRange;
        end else if (pos_quot > wspc_pkg::QuotW'(wspc_pkg::DegMax)) begin
          pos_d = wspc_pkg::DegW'(wspc_pkg::DegMax);
        end else begin
          pos_d = pos_quot[wspc_pkg::DegW-1:0];
        end
      end
      wspc_pkg::ActStop: begin
        running_d = 1'b0;
      end
      default: begin
      end
    endcase

    // A fault-free direction query reports the target side; every other beat shows the move direction.
    if ((s1_action_q == wspc_pkg::ActDirQuery) && !s1_fault_q) begin
      if (volt_ext == new_sp_ext) begin
        dir_out_d = wspc_pkg::DirRest;
      end else if (volt_ext < new_sp_ext) begin
        dir_out_d = wspc_pkg::DirCw;
      end else begin
        dir_out_d = wspc_pkg::DirCcw;
      end
    end else begin
      dir_out_d = move_dir_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign motor_power_o     = powered_q;
  assign step_running_o    = running_q;
  assign dir_level_o       = dir_pin_q;
  assign direction_out_o   = dir_out_q;
  assign steps_remaining_o = steps_left_q;
  assign position_deg_o    = pos_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> s1_valid_q)
    else $error("Input stall raised with an empty input register.");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
      advance |=> out_valid_q)
    else $error("A beat left the input register but no result appeared.");

  a_held_item_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_action_q)))
    else $error("A held input beat was lost or changed.");

  a_tick_ends_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (advance && (s1_action_q == wspc_pkg::ActTick) && tick_en_q && running_q &&
       (steps_left_q[wspc_pkg::StepsW-1] || (steps_left_q == '0)))
      |=> (!tick_en_q && !running_q && (steps_left_q == '0)))
    else $error("A spent step move did not halt the step timer.");

  a_power_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (advance && (s1_action_q == wspc_pkg::ActPowerOn)) |=> motor_power_o)
    else $error("Power on was not reflected in the result.");

endmodule
